// ----- rtl/multi_stack_bank_assert.svh -----
// Assertion macros for the multi-stack bank.
// Included by the top level; expects clk and rst_n in scope.
`ifndef MULTI_STACK_BANK_ASSERT_SVH
`define MULTI_STACK_BANK_ASSERT_SVH
`ifndef SYNTHESIS
`define MSB_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("multi_stack_bank: assertion failed");
`define MSB_NEVER(lbl, cond) `MSB_ASSERT(lbl, !(cond))
`else
`define MSB_ASSERT(lbl, prop)
`define MSB_NEVER(lbl, cond)
`endif
`endif

// ----- rtl/msb_pkg.sv -----
// Types and fixed constants of the multi-stack bank.
// No dependencies; used by multi_stack_bank and the testbench.
`timescale 1ns / 1ps

package msb_pkg;

    localparam int MAX_RESULTS = 32;
    localparam int VALUE_W     = 32;
    localparam int STACK_W     = 3;
    localparam int CODE_W      = 2;
    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 40;

    typedef enum logic [CODE_W-1:0] {
        REQ_PUSH  = 2'd0,
        REQ_POP   = 2'd1,
        REQ_DRAIN = 2'd2
    } req_t;

    typedef enum logic [CODE_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DRAIN
    } state_t;

endpackage

// ----- rtl/msb_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// Depends on nothing; instanced by multi_stack_bank.
`timescale 1ns / 1ps

module msb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/multi_stack_bank.sv -----
// Top level of the multi-stack bank: sequencer, fill counters, output register.
// Depends on msb_pkg, msb_ram and multi_stack_bank_assert.svh.
//
//  channel   dir  tdata (lsb up)                  tuser        tlast
//  s_axis    in   stack_index[2:0], push_value    req_type     -
//  m_axis    out  out_value, out_stack[2:0]       status       last
//
// Push and pop: accept, then one RAM write or count update once the result register is free.
// Unknown requests are accepted and give nothing.
// Drain: one RAM read a cycle through the single read port while the master side takes words.
// Reset clears fill counters and control only; RAM contents stay undefined, no clearing pass.
// A stalled master side holds the sequencer; the result register lets the next word in.
`timescale 1ns / 1ps

module multi_stack_bank #(
    parameter int NUM_STACKS = 8,
    parameter int DEPTH      = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // slave side
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [msb_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // stack_index[2:0], push_value[34:3]
    input  logic [msb_pkg::CODE_W-1:0]         s_axis_tuser,  // req_type[1:0]
    // master side
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [msb_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // out_value[31:0], out_stack[34:32]
    output logic [msb_pkg::CODE_W-1:0]         m_axis_tuser,  // status[1:0]
    output logic                               m_axis_tlast   // last
);

    import msb_pkg::*;

    localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;   // stack select
    localparam int FW = $clog2(DEPTH + 1);                          // fill count
    localparam int PW = $clog2(DEPTH);                              // in-stack pointer
    localparam int WORDS = NUM_STACKS * DEPTH;
    localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;

    // input word fields
    logic [STACK_W-1:0] in_stack;
    logic [VALUE_W-1:0] in_value;
    logic [SW-1:0]      in_sidx;
    logic               in_valid;

    assign in_stack = s_axis_tdata[STACK_W-1:0];
    assign in_value = s_axis_tdata[STACK_W +: VALUE_W];
    assign in_valid = (32'(in_stack) < NUM_STACKS);
    assign in_sidx  = SW'(in_stack);

    // sequencer state
    state_t             state_reg, state_next;
    logic [CODE_W-1:0]  req_reg;
    logic [STACK_W-1:0] stack_reg;
    logic [SW-1:0]      sidx_reg;
    logic               valid_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [FW-1:0]      cur_fill_reg;
    logic [AW-1:0]      base_reg;
    logic [PW-1:0]      ptr_reg, ptr_next;
    logic [FW-1:0]      rem_reg, rem_next;

    // per-stack fill counters
    logic [FW-1:0]      fill_cnt_reg [NUM_STACKS];
    logic               fill_we;
    logic [FW-1:0]      fill_wdata;

    // RAM port signals
    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;

    // result register
    logic               out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0] out_value_reg;
    logic [STACK_W-1:0] out_stack_reg;
    logic [CODE_W-1:0]  out_status_reg;
    logic               out_last_reg;

    logic               emit;
    logic [VALUE_W-1:0] e_value;
    status_t            e_status;
    logic               e_last;
    logic               can_emit;
    logic               full, empty;
    logic               accept;
    logic [PW-1:0]      top_ptr, ptr_dec;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign can_emit      = !out_valid_reg || m_axis_tready;
    assign full          = !valid_reg || (cur_fill_reg == FW'(DEPTH));
    assign empty         = (cur_fill_reg == '0);   // invalid stack latched as zero fill
    assign top_ptr       = PW'(cur_fill_reg - FW'(1));
    assign ptr_dec       = ptr_reg - PW'(1);
    assign ram_waddr     = base_reg + AW'(cur_fill_reg);

    msb_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (value_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_STACKS; i++)
            begin
                fill_cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (fill_we)
            begin
                fill_cnt_reg[sidx_reg] <= fill_wdata;
            end
        end
    end

    // request latch, pointers and result payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg      <= s_axis_tuser;
            stack_reg    <= in_stack;
            sidx_reg     <= in_sidx;
            valid_reg    <= in_valid;
            value_reg    <= in_value;
            cur_fill_reg <= in_valid ? fill_cnt_reg[in_sidx] : '0;
            base_reg     <= AW'(in_sidx) * AW'(DEPTH);
        end
        ptr_reg <= ptr_next;
        rem_reg <= rem_next;
        if (emit)
        begin
            out_value_reg  <= e_value;
            out_stack_reg  <= stack_reg;
            out_status_reg <= e_status;
            out_last_reg   <= e_last;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        rem_next   = rem_reg;
        emit       = 1'b0;
        e_value    = '0;
        e_status   = STAT_OK;
        e_last     = 1'b1;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = base_reg + AW'(top_ptr);
        fill_we    = 1'b0;
        fill_wdata = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (req_reg)
                    REQ_PUSH:
                    begin
                        if (can_emit)
                        begin
                            emit       = 1'b1;
                            state_next = ST_IDLE;
                            if (full)
                            begin
                                e_status = STAT_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                fill_we    = 1'b1;
                                fill_wdata = cur_fill_reg + FW'(1);
                            end
                        end
                    end
                    REQ_POP:
                    begin
                        if (can_emit)
                        begin
                            emit       = 1'b1;
                            state_next = ST_IDLE;
                            if (empty)
                            begin
                                e_status = STAT_EMPTY;
                            end
                            else
                            begin
                                fill_we    = 1'b1;
                                fill_wdata = cur_fill_reg - FW'(1);
                            end
                        end
                    end
                    REQ_DRAIN:
                    begin
                        if (empty)
                        begin
                            if (can_emit)
                            begin
                                emit       = 1'b1;
                                e_status   = STAT_EMPTY;
                                state_next = ST_IDLE;
                            end
                        end
                        else
                        begin
                            // fetch the top entry; result count capped at the result limit
                            ram_re     = 1'b1;
                            ptr_next   = top_ptr;
                            rem_next   = (32'(cur_fill_reg) > MAX_RESULTS) ?
                                         FW'(MAX_RESULTS) : cur_fill_reg;
                            state_next = ST_DRAIN;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;   // unknown request: no result
                    end
                endcase
            end
            ST_DRAIN:
            begin
                // read data holds while the master side stalls (no new read issued)
                if (can_emit)
                begin
                    emit    = 1'b1;
                    e_value = ram_rdata;
                    e_last  = (rem_reg == FW'(1));
                    if (rem_reg == FW'(1))
                    begin
                        fill_we    = 1'b1;
                        fill_wdata = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = base_reg + AW'(ptr_dec);
                        ptr_next  = ptr_dec;
                        rem_next  = rem_reg - FW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_DATA_W - VALUE_W - STACK_W)'(0), out_stack_reg, out_value_reg};
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

    // checks
`include "multi_stack_bank_assert.svh"

    `MSB_NEVER(a_fill_in_range, (state_reg == ST_EXEC) && (32'(cur_fill_reg) > DEPTH))
    `MSB_ASSERT(a_error_is_single, (m_axis_tvalid && (m_axis_tuser != STAT_OK)) |-> (m_axis_tlast && (out_value_reg == '0)))
    `MSB_ASSERT(a_push_counts, (state_reg == ST_EXEC && req_reg == REQ_PUSH && emit && !full) |=> (fill_cnt_reg[sidx_reg] == $past(cur_fill_reg) + FW'(1)))
    `MSB_NEVER(a_drain_has_work, (state_reg == ST_DRAIN) && (rem_reg == '0))

endmodule

// ----- sim/testbench.sv -----
// Self-checking bench for multi_stack_bank: directed and random push/pop/drain traffic on the stream ports.
// Depends on msb_pkg and the RTL top level; results are checked against a scoreboard.
`timescale 1ns / 1ps

module testbench;

    import msb_pkg::*;

    localparam int NUM_STACKS   = 8;
    localparam int DEPTH        = 32;
    localparam int RANDOM_WORDS = 180;
    localparam int IDLE_LIMIT   = 2000;   // cycles with no handshake on either side
    localparam int DRAIN_TAIL   = 40;     // settle time once nothing is awaited

    // request code outside the enum; the block should swallow it
    localparam logic [CODE_W-1:0] REQ_UNKNOWN = 2'd3;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic [STACK_W-1:0] stk;
        status_t            status;
        logic               last;
    } result_t;

    // tracks every stack's contents and holds the words still owed by the block
    class stack_scoreboard;
        logic [VALUE_W-1:0] words [NUM_STACKS][DEPTH];
        int unsigned        fill_of [NUM_STACKS];
        result_t            awaited [$];
        int                 errors;

        function new();
            foreach (fill_of[i])
                fill_of[i] = 0;
            errors = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void owe(logic [VALUE_W-1:0] v, logic [STACK_W-1:0] s, status_t st,
                          logic l);
            result_t r;
            r.value  = v;
            r.stk    = s;
            r.status = st;
            r.last   = l;
            awaited.push_back(r);
        endfunction

        // called at the edge where a request word is taken
        function void note_request(logic [CODE_W-1:0] req, logic [STACK_W-1:0] s,
                                   logic [VALUE_W-1:0] v);
            int unsigned n;
            if (req == REQ_PUSH) begin
                if (fill_of[s] >= DEPTH)
                    owe('0, s, STAT_FULL, 1'b1);
                else
                begin
                    words[s][fill_of[s]] = v;
                    fill_of[s]++;
                    owe('0, s, STAT_OK, 1'b1);
                end
            end
            else if (req == REQ_POP) begin
                if (fill_of[s] == 0)
                    owe('0, s, STAT_EMPTY, 1'b1);
                else
                begin
                    fill_of[s]--;
                    owe('0, s, STAT_OK, 1'b1);
                end
            end
            else if (req == REQ_DRAIN) begin
                if (fill_of[s] == 0)
                    owe('0, s, STAT_EMPTY, 1'b1);
                else
                begin
                    // top first; anything past the result limit is thrown away
                    n = (fill_of[s] < MAX_RESULTS) ? fill_of[s] : MAX_RESULTS;
                    for (int k = 0; k < n; k++)
                        owe(words[s][fill_of[s] - 1 - k], s, STAT_OK, k == n - 1);
                    fill_of[s] = 0;
                end
            end
            // unknown code: no result, no state change
        endfunction

        task report(string field, logic [VALUE_W-1:0] got, logic [VALUE_W-1:0] want);
            if (errors < 40)
                $display("mismatch at %0t: %s got %h want %h", $realtime, field, got, want);
            errors++;
        endtask

        task check_result(logic [VALUE_W-1:0] v, logic [STACK_W-1:0] s, status_t st,
                          logic l);
            result_t want;
            if (awaited.size() == 0) begin
                report("unexpected word", v, '0);
                return;
            end
            want = awaited.pop_front();
            if (v !== want.value)
                report("out_value", v, want.value);
            if (s !== want.stk)
                report("out_stack", s, want.stk);
            if (st !== want.status)
                report("status", st, want.status);
            if (l !== want.last)
                report("last", l, want.last);
        endtask
    endclass

    logic                    clk           = 1'b0;
    logic                    rst_n         = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata  = '0;   // stack_index[2:0], push_value[34:3]
    logic [CODE_W-1:0]       s_axis_tuser  = '0;   // req_type[1:0]
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;         // out_value[31:0], out_stack[34:32]
    logic [CODE_W-1:0]       m_axis_tuser;         // status[1:0]
    logic                    m_axis_tlast;

    stack_scoreboard sb = new();

    int burst_left = 4;
    int sent       = 0;

    multi_stack_bank #(
        .NUM_STACKS (NUM_STACKS),
        .DEPTH      (DEPTH)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // extremes turn up often, the rest is uniform
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // offer one request word, hold until taken, then maybe drop into a gap
    task automatic send_word(logic [CODE_W-1:0] req, logic [STACK_W-1:0] s,
                             logic [VALUE_W-1:0] v);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, v, s};
        s_axis_tuser  <= req;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_request(req, s, v);
        if (req != REQ_UNKNOWN)
            sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = $urandom_range(0, 6);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // hold off the sender until the block owes nothing
    task automatic pause_until_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // receiver back-pressure: a new random mode whenever the mode counter runs out
    int rx_mode  = 0;
    int rx_count = 0;
    int rx_hold  = 0;
    always @(posedge clk)
    begin
        if (rx_count == 0) begin
            rx_mode  = $urandom_range(0, 3);
            rx_count = 50;
        end
        rx_count--;
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= (rx_count % 4 == 0);
            default:
            begin
                // long runs of one level
                if (rx_hold == 0) begin
                    rx_hold = $urandom_range(1, 10);
                    m_axis_tready <= ~m_axis_tready;
                end
                rx_hold--;
            end
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata[31:0], m_axis_tdata[34:32],
                            status_t'(m_axis_tuser), m_axis_tlast);
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        wait (rst_n === 1'b1);
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("** multi_stack_bank: FAILED **");
        $finish;
    end

    initial
    begin
        logic [STACK_W-1:0] s;
        int                 kind;
        int                 len;
        int                 seq;
        bit                 paused;

        seq    = 0;
        paused = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extreme values, LIFO order, empty cases, unknown code
        send_word(REQ_PUSH,    3'd0, 32'h7FFF_FFFF);
        send_word(REQ_PUSH,    3'd0, 32'h8000_0000);
        send_word(REQ_PUSH,    3'd0, 32'h0000_0000);
        send_word(REQ_PUSH,    3'd0, 32'hFFFF_FFFF);
        send_word(REQ_POP,     3'd0, 32'h0000_0000);
        send_word(REQ_DRAIN,   3'd0, 32'hFFFF_FFFF);
        send_word(REQ_DRAIN,   3'd0, 32'h0000_0000);   // nothing left
        send_word(REQ_POP,     3'd0, 32'h0000_0000);   // pop on empty
        send_word(REQ_PUSH,    3'd7, 32'h5A5A_5A5A);
        send_word(REQ_PUSH,    3'd7, 32'hA5A5_A5A5);
        send_word(REQ_UNKNOWN, 3'd7, 32'h1234_5678);   // ignored
        send_word(REQ_DRAIN,   3'd7, 32'h0000_0000);
        send_word(REQ_POP,     3'd5, 32'hFFFF_FFFF);
        send_word(REQ_PUSH,    3'd5, 32'h0000_0001);
        send_word(REQ_PUSH,    3'd2, 32'hDEAD_BEEF);
        send_word(REQ_DRAIN,   3'd5, 32'h0000_0000);
        send_word(REQ_POP,     3'd2, 32'h0000_0000);
        send_word(REQ_DRAIN,   3'd2, 32'h0000_0000);
        pause_until_drained();

        // random: mostly runs of pushes with pops and drains, some noise
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            kind = (seq == 2) ? 9 : $urandom_range(0, 9);
            s    = STACK_W'($urandom_range(0, NUM_STACKS - 1));
            case (kind)
                0, 1, 2, 3:
                begin
                    len = $urandom_range(1, 8);
                    repeat (len) send_word(REQ_PUSH, s, pick_value());
                end
                4, 5:
                begin
                    len = $urandom_range(1, 3);
                    repeat (len) send_word(REQ_POP, s, $urandom());
                end
                6, 7:    send_word(REQ_DRAIN, s, $urandom());
                8:       send_word(CODE_W'($urandom_range(0, 3)),
                                   STACK_W'($urandom_range(0, 7)), $urandom());
                default:
                begin
                    // fill to the brim, knock on the full stack, then empty it
                    len = DEPTH - sb.fill_of[s] + $urandom_range(1, 2);
                    repeat (len) send_word(REQ_PUSH, s, pick_value());
                    send_word(REQ_DRAIN, s, $urandom());
                end
            endcase
            if (!paused && sent >= RANDOM_WORDS / 2) begin
                pause_until_drained();
                paused = 1;
            end
            seq++;
        end

        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (DRAIN_TAIL) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("** multi_stack_bank: PASSED **");
        else
            $display("** multi_stack_bank: FAILED **");
        $finish;
    end

endmodule
